// ===== hw/rtl/bta_pkg.sv =====
// Types, constants and tag helpers for the boundary-tag heap allocator.
package bta_pkg;

  // Tag word: block size in 8-byte units over the allocated bit
  localparam int unsigned TAG_W = 17;
  // Internal byte address and block size width
  localparam int unsigned BA_W  = 19;
  // Adjusted request size width (may exceed any heap size)
  localparam int unsigned AS_W  = 20;
  // Maximum number of queued tag writes per sequence
  localparam int unsigned WL_N  = 4;

  localparam logic [BA_W-1:0] WordBytes       = BA_W'(4);
  localparam logic [BA_W-1:0] DwordBytes      = BA_W'(8);
  localparam logic [BA_W-1:0] MinBlock        = BA_W'(16);
  localparam logic [BA_W-1:0] FirstPayload    = BA_W'(16);
  localparam logic [BA_W-1:0] ProloguePayload = BA_W'(8);
  localparam logic [BA_W-1:0] InitChunk       = BA_W'(4096);

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2,
    FUNC_NONE    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_OOM    = 2'd1,
    STAT_IGNORE = 2'd2
  } status_e;

  typedef enum logic {
    CFG_CHUNK = 1'b0,
    CFG_LIMIT = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_INIT_CHUNK,
    ST_IDLE,
    ST_WALK,
    ST_LIVE_HIT,
    ST_NXT_EVAL,
    ST_GROW,
    ST_FREE,
    ST_MRG_P,
    ST_MRG_N,
    ST_MRG_EVAL,
    ST_PLACE,
    ST_WRITE,
    ST_DONE
  } state_e;

  // Build a tag from a byte size and the allocated bit
  function automatic logic [TAG_W-1:0] mk_tag(logic [BA_W-1:0] size, logic used);
    return {size[BA_W-1:3], used};
  endfunction

  // Byte size held in a tag
  function automatic logic [BA_W-1:0] tag_size(logic [TAG_W-1:0] tag);
    return {tag[TAG_W-1:1], 3'b000};
  endfunction

endpackage

// ===== hw/rtl/boundary_tag_heap_allocator.sv =====
// Boundary-tag heap allocator: first-fit implicit free list over a tag memory.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   func_i, request_bytes_i, block_addr_i
//   out      source     out_valid_o / out_ready_i result_addr_o, status_o, copy_needed_o,
//                                                 copy_src_o, copy_bytes_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request at a time. The first-fit and liveness walks read one block tag per cycle
// through the single read port; each split, free, merge or extension queues two to
// four tag writes. After reset an init sequence lays out the heap; in_ready_o is
// low until it finishes. A finished result sits in the output register and a new
// request is taken while it waits; the next result waits for that register to empty.
module boundary_tag_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 262144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [18:0] request_bytes_i,
  input  logic [17:0] block_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] result_addr_o,
  output logic [1:0]  status_o,
  output logic        copy_needed_o,
  output logic [17:0] copy_src_o,
  output logic [18:0] copy_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [18:0] cfg_data_i
);

  localparam int unsigned TW    = bta_pkg::TAG_W;
  localparam int unsigned BW    = bta_pkg::BA_W;
  localparam int unsigned AW    = bta_pkg::AS_W;
  localparam int unsigned DEPTH = HEAP_BYTES / 4;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam bit InitFits =
    (32'(bta_pkg::FirstPayload) + 32'(bta_pkg::InitChunk)) <= 32'(HEAP_BYTES);
  localparam logic [BW-1:0] BrkReset = InitFits ?
    (bta_pkg::FirstPayload + bta_pkg::InitChunk) : bta_pkg::FirstPayload;

  // Tag memory
  logic [TW-1:0] mem [DEPTH];
  logic          rd_en, wr_en;
  logic [BW-1:0] rd_addr, wr_addr;
  logic [TW-1:0] wr_tag, rdata_q, rdata;
  logic [31:0]   rd_word, wr_word;
  logic          rd_ok_q;

  assign rd_word = 32'(rd_addr[BW-1:2]);
  assign wr_word = 32'(wr_addr[BW-1:2]);

  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_word < 32'(DEPTH))) begin
      mem[wr_word[IDX_W-1:0]] <= wr_tag;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_word[IDX_W-1:0]];
      rd_ok_q <= rd_word < 32'(DEPTH);
    end
  end

  // Words past the store read as zero
  assign rdata = rd_ok_q ? rdata_q : '0;

  // Control and working registers
  bta_pkg::state_e state_q, state_d, wl_ret_q, wl_ret_d;
  logic [BW-1:0] wl_addr_q [bta_pkg::WL_N];
  logic [BW-1:0] wl_addr_d [bta_pkg::WL_N];
  logic [TW-1:0] wl_tag_q  [bta_pkg::WL_N];
  logic [TW-1:0] wl_tag_d  [bta_pkg::WL_N];
  logic [1:0]    wl_last_q, wl_last_d, wl_idx_q, wl_idx_d;

  logic [1:0]    func_q, func_d;
  logic [BW-1:0] req_q, req_d;
  logic [BW-1:0] addr_q, addr_d;
  logic [AW-1:0] asize_q, asize_d;
  logic [BW-1:0] bp_q, bp_d, sz_q, sz_d, old_q, old_d;
  logic [TW-1:0] ptag_q, ptag_d;
  logic          fit_q, fit_d, grow_q, grow_d, move_q, move_d;
  logic [17:0]   r_addr_q, r_addr_d;
  logic [1:0]    r_status_q, r_status_d;
  logic          r_copy_q, r_copy_d;
  logic [BW-1:0] brk_q, brk_d;
  logic [16:0]   chunk_q;
  logic [18:0]   limit_q;

  logic          out_valid_q, out_valid_d;
  logic [17:0]   out_addr_q, out_addr_d, out_src_q, out_src_d;
  logic [1:0]    out_status_q, out_status_d;
  logic          out_copy_q, out_copy_d;
  logic [18:0]   out_bytes_q, out_bytes_d;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= 17'(bta_pkg::InitChunk);
      limit_q <= 19'd262144;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bta_pkg::CFG_CHUNK: chunk_q <= cfg_data_i[16:0];
        bta_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and datapath
  always_comb begin
    logic [BW-1:0] sz, psize, nsize, tot, nb, rest;
    logic          used;
    logic [AW-1:0] bytes;
    logic [AW:0]   gsize;
    logic [31:0]   lim;

    state_d    = state_q;
    wl_ret_d   = wl_ret_q;
    wl_addr_d  = wl_addr_q;
    wl_tag_d   = wl_tag_q;
    wl_last_d  = wl_last_q;
    wl_idx_d   = wl_idx_q;
    func_d     = func_q;
    req_d      = req_q;
    addr_d     = addr_q;
    asize_d    = asize_q;
    bp_d       = bp_q;
    sz_d       = sz_q;
    old_d      = old_q;
    ptag_d     = ptag_q;
    fit_d      = fit_q;
    grow_d     = grow_q;
    move_d     = move_q;
    r_addr_d   = r_addr_q;
    r_status_d = r_status_q;
    r_copy_d   = r_copy_q;
    brk_d      = brk_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_addr_d   = out_addr_q;
    out_src_d    = out_src_q;
    out_status_d = out_status_q;
    out_copy_d   = out_copy_q;
    out_bytes_d  = out_bytes_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = wl_addr_q[wl_idx_q];
    wr_tag     = wl_tag_q[wl_idx_q];
    in_ready_o = 1'b0;

    sz    = bta_pkg::tag_size(rdata);
    used  = rdata[0];
    psize = bta_pkg::tag_size(ptag_q);
    nsize = sz;
    tot   = '0;
    nb    = '0;
    rest  = '0;
    bytes = (asize_q > AW'(chunk_q)) ? asize_q : AW'(chunk_q);
    gsize = (((AW+1)'(bytes) + (AW+1)'(4)) >> 3) << 3;
    lim   = (32'(limit_q) < 32'(HEAP_BYTES)) ? 32'(limit_q) : 32'(HEAP_BYTES);

    case (state_q)
      // Prologue and epilogue
      bta_pkg::ST_INIT: begin
        wl_addr_d[0] = BW'(4);  wl_tag_d[0] = bta_pkg::mk_tag(bta_pkg::DwordBytes, 1'b1);
        wl_addr_d[1] = BW'(8);  wl_tag_d[1] = bta_pkg::mk_tag(bta_pkg::DwordBytes, 1'b1);
        wl_addr_d[2] = BW'(12); wl_tag_d[2] = bta_pkg::mk_tag('0, 1'b1);
        wl_last_d = 2'd2;
        wl_idx_d  = '0;
        wl_ret_d  = bta_pkg::ST_INIT_CHUNK;
        state_d   = bta_pkg::ST_WRITE;
      end
      // First free chunk
      bta_pkg::ST_INIT_CHUNK: begin
        if (InitFits) begin
          wl_addr_d[0] = bta_pkg::FirstPayload - bta_pkg::WordBytes;
          wl_tag_d[0]  = bta_pkg::mk_tag(bta_pkg::InitChunk, 1'b0);
          wl_addr_d[1] = bta_pkg::FirstPayload + bta_pkg::InitChunk - bta_pkg::DwordBytes;
          wl_tag_d[1]  = bta_pkg::mk_tag(bta_pkg::InitChunk, 1'b0);
          wl_addr_d[2] = bta_pkg::FirstPayload + bta_pkg::InitChunk - bta_pkg::WordBytes;
          wl_tag_d[2]  = bta_pkg::mk_tag('0, 1'b1);
          wl_last_d = 2'd2;
          wl_idx_d  = '0;
          wl_ret_d  = bta_pkg::ST_IDLE;
          state_d   = bta_pkg::ST_WRITE;
        end else begin
          state_d = bta_pkg::ST_IDLE;
        end
      end
      // Take a request and start the walk
      bta_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          func_d     = func_i;
          req_d      = request_bytes_i;
          addr_d     = BW'(block_addr_i);
          asize_d    = (request_bytes_i <= 19'(bta_pkg::DwordBytes)) ?
                       AW'(bta_pkg::MinBlock) :
                       (((AW'(request_bytes_i) + AW'(15)) >> 3) << 3);
          move_d     = 1'b0;
          r_addr_d   = '0;
          r_status_d = bta_pkg::STAT_IGNORE;
          r_copy_d   = 1'b0;
          state_d    = bta_pkg::ST_DONE;
          if ((func_i == bta_pkg::FUNC_ALLOC) ||
              ((func_i == bta_pkg::FUNC_REALLOC) && (block_addr_i == '0))) begin
            if (request_bytes_i != '0) begin
              fit_d   = 1'b1;
              bp_d    = bta_pkg::ProloguePayload;
              rd_en   = 1'b1;
              rd_addr = bta_pkg::ProloguePayload - bta_pkg::WordBytes;
              state_d = bta_pkg::ST_WALK;
            end
          end else if ((func_i == bta_pkg::FUNC_FREE) || (func_i == bta_pkg::FUNC_REALLOC)) begin
            if (block_addr_i != '0) begin
              fit_d   = 1'b0;
              bp_d    = bta_pkg::FirstPayload;
              rd_en   = 1'b1;
              rd_addr = bta_pkg::FirstPayload - bta_pkg::WordBytes;
              state_d = bta_pkg::ST_WALK;
            end
          end
        end
      end
      // One block header per cycle
      bta_pkg::ST_WALK: begin
        if ((bp_q >= brk_q) || (sz == '0)) begin
          state_d = fit_q ? bta_pkg::ST_GROW : bta_pkg::ST_DONE;
        end else if (fit_q && !used && (asize_q <= AW'(sz))) begin
          sz_d    = sz;
          state_d = bta_pkg::ST_PLACE;
        end else if (!fit_q && (bp_q == addr_q)) begin
          old_d   = sz;
          state_d = used ? bta_pkg::ST_LIVE_HIT : bta_pkg::ST_DONE;
        end else begin
          bp_d    = bp_q + sz;
          rd_en   = 1'b1;
          rd_addr = bp_q + sz - bta_pkg::WordBytes;
        end
      end
      // Live block found: free or reallocate
      bta_pkg::ST_LIVE_HIT: begin
        if (func_q == bta_pkg::FUNC_FREE) begin
          r_status_d = bta_pkg::STAT_OK;
          state_d    = bta_pkg::ST_FREE;
        end else if (req_q == '0) begin
          state_d = bta_pkg::ST_FREE;
        end else begin
          r_status_d = bta_pkg::STAT_OK;
          r_addr_d   = addr_q[17:0];
          if (AW'(old_q) > asize_q) begin
            // Shrink in place, tail becomes a free block
            wl_addr_d[0] = addr_q - bta_pkg::WordBytes;
            wl_tag_d[0]  = bta_pkg::mk_tag(BW'(asize_q), 1'b1);
            wl_addr_d[1] = addr_q + BW'(asize_q) - bta_pkg::DwordBytes;
            wl_tag_d[1]  = bta_pkg::mk_tag(BW'(asize_q), 1'b1);
            wl_addr_d[2] = addr_q + BW'(asize_q) - bta_pkg::WordBytes;
            wl_tag_d[2]  = bta_pkg::mk_tag(old_q - BW'(asize_q), 1'b0);
            wl_addr_d[3] = addr_q + old_q - bta_pkg::DwordBytes;
            wl_tag_d[3]  = bta_pkg::mk_tag(old_q - BW'(asize_q), 1'b0);
            wl_last_d = 2'd3;
            wl_idx_d  = '0;
            wl_ret_d  = bta_pkg::ST_DONE;
            state_d   = bta_pkg::ST_WRITE;
          end else if (AW'(old_q) == asize_q) begin
            state_d = bta_pkg::ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = addr_q + old_q - bta_pkg::WordBytes;
            state_d = bta_pkg::ST_NXT_EVAL;
          end
        end
      end
      // Grow into the next block or move
      bta_pkg::ST_NXT_EVAL: begin
        if (!used && ((AW'(nsize) + AW'(old_q)) >= asize_q)) begin
          rest = BW'(AW'(nsize) + AW'(old_q) - asize_q);
          wl_addr_d[0] = addr_q - bta_pkg::WordBytes;
          wl_tag_d[0]  = bta_pkg::mk_tag(BW'(asize_q), 1'b1);
          wl_addr_d[1] = addr_q + BW'(asize_q) - bta_pkg::DwordBytes;
          wl_tag_d[1]  = bta_pkg::mk_tag(BW'(asize_q), 1'b1);
          wl_addr_d[2] = addr_q + BW'(asize_q) - bta_pkg::WordBytes;
          wl_tag_d[2]  = bta_pkg::mk_tag(rest, 1'b0);
          wl_addr_d[3] = addr_q + BW'(asize_q) + rest - bta_pkg::DwordBytes;
          wl_tag_d[3]  = bta_pkg::mk_tag(rest, 1'b0);
          wl_last_d = (rest >= bta_pkg::DwordBytes) ? 2'd3 : 2'd1;
          wl_idx_d  = '0;
          wl_ret_d  = bta_pkg::ST_DONE;
          state_d   = bta_pkg::ST_WRITE;
        end else begin
          // New block takes the adjusted size as its request
          move_d  = 1'b1;
          asize_d = asize_q + AW'(bta_pkg::DwordBytes);
          fit_d   = 1'b1;
          bp_d    = bta_pkg::ProloguePayload;
          rd_en   = 1'b1;
          rd_addr = bta_pkg::ProloguePayload - bta_pkg::WordBytes;
          state_d = bta_pkg::ST_WALK;
        end
      end
      // Extend the heap at the break
      bta_pkg::ST_GROW: begin
        if ((gsize == '0) || ((32'(brk_q) + 32'(gsize)) > lim)) begin
          r_addr_d   = '0;
          r_status_d = bta_pkg::STAT_OOM;
          state_d    = bta_pkg::ST_DONE;
        end else begin
          wl_addr_d[0] = brk_q - bta_pkg::WordBytes;
          wl_tag_d[0]  = bta_pkg::mk_tag(BW'(gsize), 1'b0);
          wl_addr_d[1] = brk_q + BW'(gsize) - bta_pkg::DwordBytes;
          wl_tag_d[1]  = bta_pkg::mk_tag(BW'(gsize), 1'b0);
          wl_addr_d[2] = brk_q + BW'(gsize) - bta_pkg::WordBytes;
          wl_tag_d[2]  = bta_pkg::mk_tag('0, 1'b1);
          wl_last_d = 2'd2;
          wl_idx_d  = '0;
          wl_ret_d  = bta_pkg::ST_MRG_P;
          state_d   = bta_pkg::ST_WRITE;
          brk_d     = brk_q + BW'(gsize);
          bp_d      = brk_q;
          sz_d      = BW'(gsize);
          grow_d    = 1'b1;
        end
      end
      // Mark the old block free, then coalesce
      bta_pkg::ST_FREE: begin
        wl_addr_d[0] = addr_q - bta_pkg::WordBytes;
        wl_tag_d[0]  = bta_pkg::mk_tag(old_q, 1'b0);
        wl_addr_d[1] = addr_q + old_q - bta_pkg::DwordBytes;
        wl_tag_d[1]  = bta_pkg::mk_tag(old_q, 1'b0);
        wl_last_d = 2'd1;
        wl_idx_d  = '0;
        wl_ret_d  = bta_pkg::ST_MRG_P;
        state_d   = bta_pkg::ST_WRITE;
        bp_d      = addr_q;
        sz_d      = old_q;
        grow_d    = 1'b0;
      end
      // Coalesce: previous footer, then next header
      bta_pkg::ST_MRG_P: begin
        rd_en   = 1'b1;
        rd_addr = bp_q - bta_pkg::DwordBytes;
        state_d = bta_pkg::ST_MRG_N;
      end
      bta_pkg::ST_MRG_N: begin
        ptag_d  = rdata;
        rd_en   = 1'b1;
        rd_addr = bp_q + sz_q - bta_pkg::WordBytes;
        state_d = bta_pkg::ST_MRG_EVAL;
      end
      bta_pkg::ST_MRG_EVAL: begin
        if (ptag_q[0] && used) begin
          state_d = grow_q ? bta_pkg::ST_PLACE : bta_pkg::ST_DONE;
        end else begin
          if (ptag_q[0]) begin
            tot = sz_q + nsize;
            nb  = bp_q;
          end else begin
            tot = sz_q + psize + (used ? '0 : nsize);
            nb  = bp_q - psize;
          end
          wl_addr_d[0] = nb - bta_pkg::WordBytes;
          wl_tag_d[0]  = bta_pkg::mk_tag(tot, 1'b0);
          wl_addr_d[1] = nb + tot - bta_pkg::DwordBytes;
          wl_tag_d[1]  = bta_pkg::mk_tag(tot, 1'b0);
          wl_last_d = 2'd1;
          wl_idx_d  = '0;
          wl_ret_d  = grow_q ? bta_pkg::ST_PLACE : bta_pkg::ST_DONE;
          state_d   = bta_pkg::ST_WRITE;
          bp_d      = nb;
          sz_d      = tot;
        end
      end
      // Allocate the found block, splitting off a large enough remainder
      bta_pkg::ST_PLACE: begin
        rest = sz_q - BW'(asize_q);
        if (rest >= bta_pkg::MinBlock) begin
          wl_addr_d[0] = bp_q - bta_pkg::WordBytes;
          wl_tag_d[0]  = bta_pkg::mk_tag(BW'(asize_q), 1'b1);
          wl_addr_d[1] = bp_q + BW'(asize_q) - bta_pkg::DwordBytes;
          wl_tag_d[1]  = bta_pkg::mk_tag(BW'(asize_q), 1'b1);
          wl_addr_d[2] = bp_q + BW'(asize_q) - bta_pkg::WordBytes;
          wl_tag_d[2]  = bta_pkg::mk_tag(rest, 1'b0);
          wl_addr_d[3] = bp_q + sz_q - bta_pkg::DwordBytes;
          wl_tag_d[3]  = bta_pkg::mk_tag(rest, 1'b0);
          wl_last_d = 2'd3;
        end else begin
          wl_addr_d[0] = bp_q - bta_pkg::WordBytes;
          wl_tag_d[0]  = bta_pkg::mk_tag(sz_q, 1'b1);
          wl_addr_d[1] = bp_q + sz_q - bta_pkg::DwordBytes;
          wl_tag_d[1]  = bta_pkg::mk_tag(sz_q, 1'b1);
          wl_last_d = 2'd1;
        end
        wl_idx_d   = '0;
        state_d    = bta_pkg::ST_WRITE;
        r_addr_d   = bp_q[17:0];
        r_status_d = bta_pkg::STAT_OK;
        r_copy_d   = move_q;
        wl_ret_d   = move_q ? bta_pkg::ST_FREE : bta_pkg::ST_DONE;
      end
      // Drain queued tag writes
      bta_pkg::ST_WRITE: begin
        wr_en = 1'b1;
        if (wl_idx_q == wl_last_q) begin
          state_d = wl_ret_q;
        end else begin
          wl_idx_d = wl_idx_q + 2'd1;
        end
      end
      // Hand the result to the output register
      bta_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = r_addr_q;
          out_status_d = r_status_q;
          out_copy_d   = r_copy_q;
          out_src_d    = r_copy_q ? addr_q[17:0] : '0;
          out_bytes_d  = r_copy_q ? (old_q - bta_pkg::DwordBytes) : '0;
          state_d      = bta_pkg::ST_IDLE;
        end
      end
      default: state_d = bta_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bta_pkg::ST_INIT;
      wl_ret_q    <= bta_pkg::ST_IDLE;
      wl_last_q   <= '0;
      wl_idx_q    <= '0;
      brk_q       <= BrkReset;
      out_valid_q <= 1'b0;
      fit_q       <= 1'b0;
      grow_q      <= 1'b0;
      move_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_ret_q    <= wl_ret_d;
      wl_last_q   <= wl_last_d;
      wl_idx_q    <= wl_idx_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
      fit_q       <= fit_d;
      grow_q      <= grow_d;
      move_q      <= move_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    wl_addr_q    <= wl_addr_d;
    wl_tag_q     <= wl_tag_d;
    func_q       <= func_d;
    req_q        <= req_d;
    addr_q       <= addr_d;
    asize_q      <= asize_d;
    bp_q         <= bp_d;
    sz_q         <= sz_d;
    old_q        <= old_d;
    ptag_q       <= ptag_d;
    r_addr_q     <= r_addr_d;
    r_status_q   <= r_status_d;
    r_copy_q     <= r_copy_d;
    out_addr_q   <= out_addr_d;
    out_src_q    <= out_src_d;
    out_status_q <= out_status_d;
    out_copy_q   <= out_copy_d;
    out_bytes_q  <= out_bytes_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_addr_o = out_addr_q;
  assign status_o      = out_status_q;
  assign copy_needed_o = out_copy_q;
  assign copy_src_o    = out_src_q;
  assign copy_bytes_o  = out_bytes_q;

`ifndef SYNTHESIS
  // The heap break only moves up
  a_brk_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q >= $past(brk_q)) else $error("heap break moved down");

  // The break stays double-word aligned
  a_brk_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    brk_q[2:0] == 3'b000) else $error("heap break misaligned");

  // A move is only reported with a successful result
  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && copy_needed_o |-> status_o == bta_pkg::STAT_OK && result_addr_o != '0)
    else $error("copy reported without a new block");

  // No request is taken while tag writes are pending
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bta_pkg::ST_WRITE |-> !in_ready_o) else $error("accept during write");
`endif

endmodule

// ===== dv/boundary_tag_heap_allocator_test.sv =====
// Self-checking testbench for the boundary-tag heap allocator (first-fit, boundary tags).
module boundary_tag_heap_allocator_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HeapBytes  = 262144;
  localparam int unsigned StoreWords = HeapBytes / 4;
  localparam int unsigned RandItems  = 1525;

  typedef struct packed {
    logic [17:0]      addr;
    bta_pkg::status_e stat;
    logic             copy;
    logic [17:0]      src;
    logic [18:0]      nbytes;
  } alloc_result_t;

  typedef struct {
    bta_pkg::func_e   fn;
    logic [18:0]      req;
    logic [17:0]      addr;
    bit               typed;
    logic [17:0]      exp_addr;
    bta_pkg::status_e exp_stat;
  } request_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = bta_pkg::FUNC_ALLOC;
  logic [18:0] request_bytes_i = '0;
  logic [17:0] block_addr_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [17:0] result_addr_o;
  logic [1:0]  status_o;
  logic        copy_needed_o;
  logic [17:0] copy_src_o;
  logic [18:0] copy_bytes_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = bta_pkg::CFG_CHUNK;
  logic [18:0] cfg_data_i = '0;

  boundary_tag_heap_allocator #(.HEAP_BYTES(HeapBytes)) i_dut (.*);

  always #10 clk_i = ~clk_i;

  // Heap shadow: tag words, break and registers
  int unsigned   heap_tags [StoreWords];
  int unsigned   heap_top;
  int unsigned   chunk_size;
  int unsigned   break_limit;
  alloc_result_t pending_results [$];
  int            fail_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            phase_num = 0;

  function automatic int unsigned tag_rd(int unsigned a);
    int unsigned i;
    i = a >> 2;
    return (i < StoreWords) ? heap_tags[i] : 0;
  endfunction

  function automatic void tag_wr(int unsigned a, int unsigned v);
    int unsigned i;
    i = a >> 2;
    if (i < StoreWords) heap_tags[i] = v;
  endfunction

  function automatic int unsigned size_at(int unsigned bp);
    return tag_rd(bp - 4) & ~32'h7;
  endfunction

  function automatic bit used_at(int unsigned bp);
    return 1'(tag_rd(bp - 4) & 1);
  endfunction

  function automatic void write_block(int unsigned bp, int unsigned sz, bit used);
    tag_wr(bp - 4, sz | used);
    tag_wr(bp + sz - 8, sz | used);
  endfunction

  // Merge with free neighbors, return the surviving payload offset
  function automatic int unsigned coalesce(int unsigned bp);
    int unsigned ptag, sz, psz;
    bit pfree, nfree;
    ptag  = tag_rd(bp - 8);
    sz    = size_at(bp);
    pfree = (ptag & 1) == 0;
    nfree = !used_at(bp + sz);
    psz   = ptag & ~32'h7;
    if (!pfree && !nfree) return bp;
    if (!pfree) begin
      write_block(bp, sz + size_at(bp + sz), 1'b0);
      return bp;
    end
    if (nfree) sz += size_at(bp + sz);
    sz += psz;
    write_block(bp - psz, sz, 1'b0);
    return bp - psz;
  endfunction

  function automatic int unsigned grow_shadow(int unsigned bytes);
    int unsigned words, bp;
    longint unsigned sz, lim;
    words = bytes / 4;
    if (words & 1) words++;
    sz  = longint'(words) * 4;
    lim = (break_limit < HeapBytes) ? break_limit : HeapBytes;
    if (sz == 0 || longint'(heap_top) + sz > lim) return 0;
    bp = heap_top;
    write_block(bp, int'(sz), 1'b0);
    tag_wr(bp + int'(sz) - 4, 1);
    heap_top += int'(sz);
    return coalesce(bp);
  endfunction

  function automatic int unsigned round_request(int unsigned req);
    if (req <= 8) return 16;
    return 8 * ((req + 15) / 8);
  endfunction

  function automatic int unsigned scan_fit(int unsigned asize);
    int unsigned bp, sz;
    bp = 8;
    while (bp < heap_top) begin
      sz = size_at(bp);
      if (sz == 0) break;
      if (!used_at(bp) && asize <= sz) return bp;
      bp += sz;
    end
    return 0;
  endfunction

  function automatic bit is_allocated(int unsigned addr);
    int unsigned bp, sz;
    bp = 16;
    while (bp < heap_top) begin
      sz = size_at(bp);
      if (sz == 0) break;
      if (bp == addr) return used_at(bp);
      bp += sz;
    end
    return 1'b0;
  endfunction

  function automatic void carve(int unsigned bp, int unsigned asize);
    int unsigned csize;
    csize = size_at(bp);
    if (csize - asize >= 16) begin
      write_block(bp, asize, 1'b1);
      write_block(bp + asize, csize - asize, 1'b0);
    end else begin
      write_block(bp, csize, 1'b1);
    end
  endfunction

  function automatic int unsigned heap_alloc(int unsigned req, output bta_pkg::status_e st);
    int unsigned asize, bp;
    if (req == 0) begin
      st = bta_pkg::STAT_IGNORE;
      return 0;
    end
    asize = round_request(req);
    bp = scan_fit(asize);
    if (bp == 0) begin
      bp = grow_shadow(asize > chunk_size ? asize : chunk_size);
      if (bp == 0) begin
        st = bta_pkg::STAT_OOM;
        return 0;
      end
    end
    carve(bp, asize);
    st = bta_pkg::STAT_OK;
    return bp;
  endfunction

  function automatic void heap_free(int unsigned bp);
    write_block(bp, size_at(bp), 1'b0);
    void'(coalesce(bp));
  endfunction

  function automatic void heap_reset();
    foreach (heap_tags[i]) heap_tags[i] = 0;
    chunk_size  = 4096;
    break_limit = 262144;
    tag_wr(4, 9);
    tag_wr(8, 9);
    tag_wr(12, 1);
    heap_top = 16;
    void'(grow_shadow(chunk_size));
  endfunction

  // Apply one request to the shadow heap and return what the block must answer
  function automatic alloc_result_t predict_request(bta_pkg::func_e fn, int unsigned req,
                                                    int unsigned addr);
    alloc_result_t r;
    bta_pkg::status_e st;
    int unsigned asize, old, nxt, nsize, rest, res;
    r = '{addr: '0, stat: bta_pkg::STAT_IGNORE, copy: 1'b0, src: '0, nbytes: '0};
    res = 0;
    st = bta_pkg::STAT_IGNORE;
    case (fn)
      bta_pkg::FUNC_ALLOC: res = heap_alloc(req, st);
      bta_pkg::FUNC_FREE: begin
        if (addr != 0 && is_allocated(addr)) begin
          heap_free(addr);
          st = bta_pkg::STAT_OK;
        end
      end
      bta_pkg::FUNC_REALLOC: begin
        if (addr == 0) begin
          res = heap_alloc(req, st);
        end else if (!is_allocated(addr)) begin
          st = bta_pkg::STAT_IGNORE;
        end else if (req == 0) begin
          heap_free(addr);
          st = bta_pkg::STAT_IGNORE;
        end else begin
          asize = round_request(req);
          old = size_at(addr);
          nxt = addr + old;
          st = bta_pkg::STAT_OK;
          res = addr;
          if (old > asize) begin
            // shrink: tail always split off, not merged
            write_block(addr, asize, 1'b1);
            write_block(addr + asize, old - asize, 1'b0);
          end else if (old < asize) begin
            nsize = size_at(nxt);
            if (!used_at(nxt) && nsize + old >= asize) begin
              rest = nsize + old - asize;
              write_block(addr, asize, 1'b1);
              if (rest >= 8) write_block(addr + asize, rest, 1'b0);
            end else begin
              // move: adjusted size is taken as the new request
              res = heap_alloc(asize, st);
              if (res != 0) begin
                r.copy   = 1'b1;
                r.src    = addr[17:0];
                r.nbytes = 19'(old - 8);
                heap_free(addr);
              end
            end
          end
        end
      end
      default: st = bta_pkg::STAT_IGNORE;
    endcase
    r.addr = res[17:0];
    r.stat = st;
    return r;
  endfunction

  // Payload offsets of all allocated blocks in the shadow heap
  function automatic void live_blocks(ref int unsigned found [$]);
    int unsigned bp, sz;
    found.delete();
    bp = 16;
    while (bp < heap_top) begin
      sz = size_at(bp);
      if (sz == 0) break;
      if (used_at(bp)) found.push_back(bp);
      bp += sz;
    end
  endfunction

  // Offer one request; predict at the accepting edge
  task automatic send_request(bta_pkg::func_e fn, logic [18:0] req, logic [17:0] addr,
                              bit typed = 0, logic [17:0] exp_addr = '0,
                              bta_pkg::status_e exp_stat = bta_pkg::STAT_OK);
    alloc_result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= fn;
    request_bytes_i <= req;
    block_addr_i    <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_request(fn, req, addr);
    if (typed) begin
      r.addr = exp_addr;
      r.stat = exp_stat;
    end
    pending_results.push_back(r);
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic write_reg(bta_pkg::cfg_e idx, logic [18:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == bta_pkg::CFG_CHUNK) chunk_size = data[16:0];
    else break_limit = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    int unsigned live [$];
    int unsigned pick, addr, req;
    bta_pkg::func_e fn;
    repeat (count) begin
      live_blocks(live);
      pick = $urandom_range(99);
      if (live.size() > 48) pick = (pick < 60) ? 50 : pick;
      if (pick < 40) fn = bta_pkg::FUNC_ALLOC;
      else if (pick < 75) fn = bta_pkg::FUNC_FREE;
      else if (pick < 96) fn = bta_pkg::FUNC_REALLOC;
      else fn = bta_pkg::FUNC_NONE;
      pick = $urandom_range(99);
      if (pick < 80 && live.size() != 0) addr = live[$urandom_range(live.size() - 1)];
      else if (pick < 88) addr = 0;
      else addr = $urandom_range(262143);
      pick = $urandom_range(99);
      if (pick < 5) req = 0;
      else if (pick < 62) req = $urandom_range(64, 1);
      else if (pick < 88) req = $urandom_range(1024, 65);
      else if (pick < 97) req = $urandom_range(8192, 1025);
      else req = $urandom_range(262144, 8193);
      send_request(fn, 19'(req), 18'(addr));
    end
    drop_valid();
  endtask

  // Result checker
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%0d status=%0d", $time, result_addr_o,
                 status_o);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (result_addr_o !== e.addr || status_o !== e.stat || copy_needed_o !== e.copy ||
            copy_src_o !== e.src || copy_bytes_o !== e.nbytes) begin
          $display("%0t: mismatch expected addr=%0d status=%0d copy=%0d src=%0d bytes=%0d",
                   $time, e.addr, e.stat, e.copy, e.src, e.nbytes);
          $display("%0t:          actual   addr=%0d status=%0d copy=%0d src=%0d bytes=%0d",
                   $time, result_addr_o, status_o, copy_needed_o, copy_src_o, copy_bytes_o);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off in the pressure phase
  initial begin
    int hold;
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_num == 4 && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Directed rows: typed expectations only for obvious answers
  request_row_t directed [] = '{
    '{bta_pkg::FUNC_ALLOC,   19'd0,      18'd0,      1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_FREE,    19'd0,      18'd0,      1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_NONE,    19'd5,      18'd16,     1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_ALLOC,   19'd1,      18'd0,      1, 18'd16, bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_ALLOC,   19'd8,      18'd0,      1, 18'd32, bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_ALLOC,   19'd9,      18'd0,      1, 18'd48, bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_FREE,    19'd0,      18'd32,     1, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_FREE,    19'd0,      18'd32,     1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_FREE,    19'd0,      18'd40,     1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_ALLOC,   19'd262144, 18'd0,      1, 18'd0,  bta_pkg::STAT_OOM},
    '{bta_pkg::FUNC_REALLOC, 19'd1,      18'd262143, 1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_REALLOC, 19'd0,      18'd0,      1, 18'd0,  bta_pkg::STAT_IGNORE},
    '{bta_pkg::FUNC_REALLOC, 19'd24,     18'd0,      0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_REALLOC, 19'd20,     18'd16,     0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_REALLOC, 19'd4,      18'd48,     0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_REALLOC, 19'd2000,   18'd16,     0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_ALLOC,   19'd4000,   18'd0,      0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_ALLOC,   19'd131071, 18'd0,      0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_REALLOC, 19'd0,      18'd48,     0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_FREE,    19'd0,      18'd16,     0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_FREE,    19'd0,      18'd64,     0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_ALLOC,   19'd65535,  18'd0,      0, 18'd0,  bta_pkg::STAT_OK},
    '{bta_pkg::FUNC_NONE,    19'h7FFFF,  18'h3FFFF,  1, 18'd0,  bta_pkg::STAT_IGNORE}
  };

  initial begin
    heap_reset();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed checks on the reset layout, no idling
    foreach (directed[i])
      send_request(directed[i].fn, directed[i].req, directed[i].addr, directed[i].typed,
                   directed[i].exp_addr, directed[i].exp_stat);
    drop_valid();
    wait_drained();

    // Tightest settings: smallest granule, lowest limit
    phase_num = 1;
    send_idle_pct = 30;
    recv_stall_pct = 50;
    write_reg(bta_pkg::CFG_CHUNK, 19'd16);
    write_reg(bta_pkg::CFG_LIMIT, 19'd4096);
    send_random(RandItems / 5);
    wait_drained();

    phase_num = 2;
    send_idle_pct = 50;
    recv_stall_pct = 30;
    write_reg(bta_pkg::CFG_CHUNK, 19'd65536);
    write_reg(bta_pkg::CFG_LIMIT, 19'd262144);
    send_random(RandItems / 5);
    wait_drained();

    phase_num = 3;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(bta_pkg::CFG_CHUNK, 19'(8 * $urandom_range(64, 2)));
    write_reg(bta_pkg::CFG_LIMIT, 19'(8 * $urandom_range(32768, 512)));
    send_random(RandItems / 5);
    wait_drained();

    // Receiver holds off while requests keep coming
    phase_num = 4;
    write_reg(bta_pkg::CFG_CHUNK, 19'd4096);
    write_reg(bta_pkg::CFG_LIMIT, 19'd262144);
    send_random(RandItems / 5);
    wait_drained();

    phase_num = 5;
    send_idle_pct = 20;
    recv_stall_pct = 20;
    write_reg(bta_pkg::CFG_CHUNK, 19'(8 * $urandom_range(8192, 2)));
    write_reg(bta_pkg::CFG_LIMIT, 19'(8 * $urandom_range(32768, 512)));
    send_random(RandItems - 4 * (RandItems / 5));
    wait_drained();

    if (fail_count == 0) $display("** boundary_tag_heap_allocator: PASSED **");
    else $display("** boundary_tag_heap_allocator: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #200ms;
    $display("** boundary_tag_heap_allocator: FAILED **");
    $finish;
  end

endmodule
